// File: hdl/kfra_pkg.sv
// Package for the bus frame receive assembler: shared constants and the
// result record passed from the decoder to the top level. No dependencies.
`timescale 1ns / 1ps

package kfra_pkg;

    // Start-of-frame test on the control byte
    localparam logic [7:0] START_MASK  = 8'hD3;
    localparam logic [7:0] START_MATCH = 8'h90;
    // Running check value at frame start
    localparam logic [7:0] CHECK_INIT  = 8'hFF;
    // Acknowledge request byte sent for group frames (for reference by users)
    localparam logic [7:0] ACK_BYTE    = 8'h11;

    // Frame layout
    localparam int HDR_BYTES   = 6;   // control, 2x source, 2x dest, length
    localparam int LEN_POS     = 5;   // byte holding flags and length nibble
    localparam int APDU_CAP    = 14;  // payload bytes delivered at most
    localparam int MIN_FRAME   = 9;   // shorter frames are dropped
    localparam int BASE_LEN    = 8;   // frame length is this plus the nibble
    localparam int BUF_BYTES   = HDR_BYTES + APDU_CAP;  // bytes ever read back
    localparam int LEN_W       = 5;   // holds expected length up to 23

    typedef logic [7:0] t_byte;
    typedef t_byte t_frame_bytes [BUF_BYTES];

    // One decoded frame
    typedef struct packed {
        logic [7:0]  ctrl_byte;
        logic [15:0] source_address;
        logic [15:0] destination_address;
        logic        group_flag;
        logic [2:0]  routing_counter;
        logic [3:0]  apdu_length;
        logic [63:0] apdu_low;
        logic [47:0] apdu_high;
        logic        ack_request;
    } t_result;

endpackage

// File: hdl/knx_frame_receive_assembler_unit.sv
// Top level of the bus frame receive assembler: byte intake, frame state,
// result register. Depends on kfra_pkg and kfra_decode.
//
// Takes one received bus byte per clock while the intake is not stalled. Idle
// bytes are skipped until a control byte matches the start pattern; the frame
// length then follows from the low nibble of byte 5. A frame that completes
// with at least nine bytes and a good XOR check yields one result, shown on
// the result register in the cycle after its last byte; short, bad or
// overlong (MAX_FRAME_BYTES reached first) frames give nothing. Byte intake
// stalls only while a result waits in the result register and the far side
// stalls it. The group flag also drives o_ack_request: an acknowledge byte
// must be sent for such a frame before delivery.
`timescale 1ns / 1ps

module knx_frame_receive_assembler_unit #(
    parameter int MAX_FRAME_BYTES = 23
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte intake
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // result
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [7:0]  o_ctrl_byte,
    output logic [15:0] o_source_address,
    output logic [15:0] o_destination_address,
    output logic        o_group_flag,
    output logic [2:0]  o_routing_counter,
    output logic [3:0]  o_apdu_length,
    output logic [63:0] o_apdu_low,
    output logic [47:0] o_apdu_high,
    output logic        o_ack_request
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic                         r_receiving, n_receiving;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [kfra_pkg::LEN_W-1:0]   r_expected, n_expected;
    logic [7:0]                   r_check, n_check;
    kfra_pkg::t_frame_bytes       r_buf;
    logic                         r_res_valid;
    kfra_pkg::t_result            r_res;

    logic                         w_accept;
    logic                         w_emit;
    logic [CNT_W-1:0]             w_count_inc;
    logic [7:0]                   w_check_inc;
    kfra_pkg::t_result            w_dec;

    assign o_rx_stall = r_res_valid && i_res_stall;
    assign w_accept   = i_rx_valid && !o_rx_stall;

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_check_inc = r_check ^ i_rx_byte;

    // Frame state update
    always_comb begin
        n_receiving = r_receiving;
        n_count     = r_count;
        n_expected  = r_expected;
        n_check     = r_check;
        w_emit      = 1'b0;
        if (w_accept) begin
            if (!r_receiving) begin
                if ((i_rx_byte & kfra_pkg::START_MASK) == kfra_pkg::START_MATCH) begin
                    n_receiving = 1'b1;
                    n_count     = CNT_W'(1);
                    n_expected  = '0;
                    n_check     = kfra_pkg::CHECK_INIT ^ i_rx_byte;
                end
            end else begin
                n_count = w_count_inc;
                n_check = w_check_inc;
                // length byte just arrived
                if (int'(w_count_inc) == kfra_pkg::LEN_POS + 1) begin
                    n_expected = kfra_pkg::LEN_W'(kfra_pkg::BASE_LEN)
                               + {1'b0, i_rx_byte[3:0]};
                end
                // frame complete
                if (r_expected != '0 && int'(w_count_inc) == int'(r_expected)) begin
                    w_emit = (int'(r_expected) >= kfra_pkg::MIN_FRAME)
                          && (w_check_inc == 8'h00);
                end
                if ((r_expected != '0 && int'(w_count_inc) == int'(r_expected))
                    || int'(w_count_inc) >= MAX_FRAME_BYTES) begin
                    n_receiving = 1'b0;
                    n_count     = '0;
                    n_expected  = '0;
                    n_check     = kfra_pkg::CHECK_INIT;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_count     <= '0;
            r_expected  <= '0;
            r_check     <= kfra_pkg::CHECK_INIT;
            r_res_valid <= 1'b0;
        end else begin
            r_receiving <= n_receiving;
            r_count     <= n_count;
            r_expected  <= n_expected;
            r_check     <= n_check;
            if (w_emit) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Frame byte store: start byte at 0, later bytes at the running count
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_receiving) begin
                r_buf[0] <= i_rx_byte;
            end else begin
                for (int i = 1; i < kfra_pkg::BUF_BYTES; i++) begin
                    if (int'(r_count) == i) begin
                        r_buf[i] <= i_rx_byte;
                    end
                end
            end
        end
    end

    kfra_decode u_decode (
        .i_bytes  (r_buf),
        .o_result (w_dec)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= w_dec;
        end
    end

    assign o_res_valid           = r_res_valid;
    assign o_ctrl_byte           = r_res.ctrl_byte;
    assign o_source_address      = r_res.source_address;
    assign o_destination_address = r_res.destination_address;
    assign o_group_flag          = r_res.group_flag;
    assign o_routing_counter     = r_res.routing_counter;
    assign o_apdu_length         = r_res.apdu_length;
    assign o_apdu_low            = r_res.apdu_low;
    assign o_apdu_high           = r_res.apdu_high;
    assign o_ack_request         = r_res.ack_request;

endmodule

// File: hdl/kfra_decode.sv
// Field decoder: turns the stored frame bytes into one result record.
// Depends on kfra_pkg.
`timescale 1ns / 1ps

module kfra_decode (
    input  kfra_pkg::t_frame_bytes i_bytes,
    output kfra_pkg::t_result      o_result
);

    logic [3:0]   w_nib;
    logic [3:0]   w_len;
    logic [111:0] w_apdu;

    // Payload length: nibble plus one, capped
    assign w_nib = i_bytes[kfra_pkg::LEN_POS][3:0];
    assign w_len = (w_nib >= 4'(kfra_pkg::APDU_CAP - 1)) ? 4'(kfra_pkg::APDU_CAP)
                                                        : w_nib + 4'd1;

    // Payload bytes, zero past the length
    always_comb begin
        w_apdu = '0;
        for (int i = 0; i < kfra_pkg::APDU_CAP; i++) begin
            if (i < int'(w_len)) begin
                w_apdu[8*i +: 8] = i_bytes[kfra_pkg::HDR_BYTES + i];
            end
        end
    end

    always_comb begin
        o_result.ctrl_byte           = i_bytes[0];
        o_result.source_address      = {i_bytes[1], i_bytes[2]};
        o_result.destination_address = {i_bytes[3], i_bytes[4]};
        o_result.group_flag          = i_bytes[kfra_pkg::LEN_POS][7];
        o_result.routing_counter     = i_bytes[kfra_pkg::LEN_POS][6:4];
        o_result.apdu_length         = w_len;
        o_result.apdu_low            = w_apdu[63:0];
        o_result.apdu_high           = w_apdu[111:64];
        o_result.ack_request         = i_bytes[kfra_pkg::LEN_POS][7];
    end

endmodule

// File: hdl/kfra_checker.sv
// Port-level checks for the frame receive assembler, bound to the top level.
// Depends on knx_frame_receive_assembler_unit.
`timescale 1ns / 1ps

module kfra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_stall,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic [15:0] o_source_address,
    input logic [15:0] o_destination_address,
    input logic        o_group_flag,
    input logic [3:0]  o_apdu_length,
    input logic [47:0] o_apdu_high,
    input logic        o_ack_request
);

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_source_address)
            && $stable(o_destination_address) && $stable(o_apdu_high))
        else $error("stalled result changed");

    // intake only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("intake stalled without a blocked result");

    // payload length within range, ack request follows group flag
    a_len_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_apdu_length >= 4'd1 && o_apdu_length <= 4'd14
            && o_ack_request == o_group_flag)
        else $error("bad length or ack request");

    // short payload leaves upper bytes clear
    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_apdu_length <= 4'd8 |-> o_apdu_high == 48'd0)
        else $error("payload bytes past length not zero");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind knx_frame_receive_assembler_unit kfra_checker u_kfra_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_rx_stall            (o_rx_stall),
    .o_res_valid           (o_res_valid),
    .i_res_stall           (i_res_stall),
    .o_source_address      (o_source_address),
    .o_destination_address (o_destination_address),
    .o_group_flag          (o_group_flag),
    .o_apdu_length         (o_apdu_length),
    .o_apdu_high           (o_apdu_high),
    .o_ack_request         (o_ack_request)
);

// File: dv/knx_frame_receive_checker.sv
// Checker for the bus frame receive assembler: tracks every byte accepted at
// the intake, predicts decoded frames and compares them with the result port.
// Depends on kfra_pkg.
`timescale 1ns / 1ps

module knx_frame_receive_checker #(
    parameter int MAX_FRAME_BYTES = 23
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte intake
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // result
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [7:0]  i_ctrl_byte,
    input  logic [15:0] i_source_address,
    input  logic [15:0] i_destination_address,
    input  logic        i_group_flag,
    input  logic [2:0]  i_routing_counter,
    input  logic [3:0]  i_apdu_length,
    input  logic [63:0] i_apdu_low,
    input  logic [47:0] i_apdu_high,
    input  logic        i_ack_request,
    // status for the test top
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] LEN_NIBBLE = 8'h0F;

    // Predictor state: one frame in progress
    logic        in_frame;
    int unsigned got_bytes;
    int unsigned frame_len;
    logic [7:0]  frame_xor;
    logic [7:0]  frame_bytes [MAX_FRAME_BYTES];

    kfra_pkg::t_result frames_due [$];
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic void clear_frame();
        in_frame  = 1'b0;
        got_bytes = 0;
        frame_len = 0;
        frame_xor = kfra_pkg::CHECK_INIT;
    endfunction

    // Decoded fields of the frame now held in frame_bytes
    function automatic kfra_pkg::t_result decode_frame();
        kfra_pkg::t_result r;
        logic [7:0]        b5;
        int unsigned       n_apdu;
        int unsigned       i;
        b5     = frame_bytes[kfra_pkg::LEN_POS];
        n_apdu = int'(b5 & LEN_NIBBLE) + 1;
        if (n_apdu > kfra_pkg::APDU_CAP)
            n_apdu = kfra_pkg::APDU_CAP;
        r = '0;
        r.ctrl_byte           = frame_bytes[0];
        r.source_address      = {frame_bytes[1], frame_bytes[2]};
        r.destination_address = {frame_bytes[3], frame_bytes[4]};
        r.group_flag          = b5[7];
        r.routing_counter     = b5[6:4];
        r.apdu_length         = n_apdu[3:0];
        for (i = 0; i < n_apdu; i++) begin
            if (i < 8)
                r.apdu_low[8*i +: 8] = frame_bytes[kfra_pkg::HDR_BYTES + i];
            else
                r.apdu_high[8*(i-8) +: 8] = frame_bytes[kfra_pkg::HDR_BYTES + i];
        end
        r.ack_request = b5[7];
        return r;
    endfunction

    // Advance the frame state by one accepted byte
    function automatic void take_byte(input logic [7:0] b);
        if (!in_frame) begin
            // idle: only a start pattern opens a frame
            if ((b & kfra_pkg::START_MASK) == kfra_pkg::START_MATCH) begin
                in_frame       = 1'b1;
                frame_bytes[0] = b;
                got_bytes      = 1;
                frame_len      = 0;
                frame_xor      = kfra_pkg::CHECK_INIT ^ b;
            end
        end else begin
            if (got_bytes < MAX_FRAME_BYTES)
                frame_bytes[got_bytes] = b;
            got_bytes++;
            frame_xor ^= b;
            if (got_bytes == kfra_pkg::HDR_BYTES)
                frame_len = kfra_pkg::BASE_LEN
                          + int'(frame_bytes[kfra_pkg::LEN_POS] & LEN_NIBBLE);
            if (frame_len > 0 && got_bytes >= frame_len) begin
                // complete: short or bad-check frames vanish
                if (got_bytes >= kfra_pkg::MIN_FRAME && frame_xor == 8'h00)
                    frames_due.push_back(decode_frame());
                clear_frame();
            end
            // overlong frame is abandoned
            if (got_bytes >= MAX_FRAME_BYTES)
                clear_frame();
        end
    endfunction

    // Results are checked before the byte of the same edge is absorbed
    always @(posedge i_clk) begin : watch
        kfra_pkg::t_result want;
        if (!i_rst_n) begin
            clear_frame();
            frames_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (frames_due.size() == 0) begin
                    report_mismatch("unexpected result, ctrl_byte", 64'(i_ctrl_byte), '0);
                end else begin
                    want = frames_due.pop_front();
                    check_field("ctrl_byte", 64'(i_ctrl_byte), 64'(want.ctrl_byte));
                    check_field("source_address", 64'(i_source_address),
                                64'(want.source_address));
                    check_field("destination_address", 64'(i_destination_address),
                                64'(want.destination_address));
                    check_field("group_flag", 64'(i_group_flag), 64'(want.group_flag));
                    check_field("routing_counter", 64'(i_routing_counter),
                                64'(want.routing_counter));
                    check_field("apdu_length", 64'(i_apdu_length), 64'(want.apdu_length));
                    check_field("apdu_low", i_apdu_low, want.apdu_low);
                    check_field("apdu_high", 64'(i_apdu_high), 64'(want.apdu_high));
                    check_field("ack_request", 64'(i_ack_request), 64'(want.ack_request));
                end
            end
            if (i_rx_valid && !i_rx_stall)
                take_byte(i_rx_byte);
        end
        o_pending <= frames_due.size();
    end

endmodule

// File: dv/tb_knx_frame_receive_assembler_unit.sv
// Test top for the bus frame receive assembler: clock, reset, byte and result
// traffic, verdict. Depends on kfra_pkg, knx_frame_receive_assembler_unit and
// knx_frame_receive_checker.
`timescale 1ns / 1ps

module tb_knx_frame_receive_assembler_unit;

    localparam int MAX_FRAME_BYTES = 23;
    localparam int HOLD_CYCLES     = 200;
    localparam int LIMIT_NS        = 400000;
    localparam int MIN_BYTES       = 400;

    typedef enum int {INTACT, BAD_CHECK, CUT_SHORT} t_frame_flaw;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  ctrl_byte;
    logic [15:0] source_address;
    logic [15:0] destination_address;
    logic        group_flag;
    logic [2:0]  routing_counter;
    logic [3:0]  apdu_length;
    logic [63:0] apdu_low;
    logic [47:0] apdu_high;
    logic        ack_request;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 24;
    int   recv_idle_pct = 48;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;
    int   bytes_sent    = 0;

    always #1 clk = ~clk;

    knx_frame_receive_assembler_unit #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_rx_valid            (rx_valid),
        .o_rx_stall            (rx_stall),
        .i_rx_byte             (rx_byte),
        .o_res_valid           (res_valid),
        .i_res_stall           (res_stall),
        .o_ctrl_byte           (ctrl_byte),
        .o_source_address      (source_address),
        .o_destination_address (destination_address),
        .o_group_flag          (group_flag),
        .o_routing_counter     (routing_counter),
        .o_apdu_length         (apdu_length),
        .o_apdu_low            (apdu_low),
        .o_apdu_high           (apdu_high),
        .o_ack_request         (ack_request)
    );

    knx_frame_receive_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) frame_chk (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_rx_valid            (rx_valid),
        .i_rx_stall            (rx_stall),
        .i_rx_byte             (rx_byte),
        .i_res_valid           (res_valid),
        .i_res_stall           (res_stall),
        .i_ctrl_byte           (ctrl_byte),
        .i_source_address      (source_address),
        .i_destination_address (destination_address),
        .i_group_flag          (group_flag),
        .i_routing_counter     (routing_counter),
        .i_apdu_length         (apdu_length),
        .i_apdu_low            (apdu_low),
        .i_apdu_high           (apdu_high),
        .i_ack_request         (ack_request),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    // Result side: random stalls, or a long hold-off when requested
    always @(posedge clk) begin
        if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one byte, with optional idle cycles first; returns once accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
    endtask

    // Build a frame with random addresses and payload; the flaw breaks it
    task automatic send_frame(input logic [7:0] ctrl, input logic [3:0] nibble,
                              input logic grp, input t_frame_flaw flaw);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        int         cut;
        int         k;
        bytes.push_back(ctrl);
        repeat (4) bytes.push_back(8'($urandom));
        bytes.push_back({grp, 3'($urandom), nibble});
        repeat (int'(nibble) + 1) bytes.push_back(8'($urandom));
        sum = kfra_pkg::CHECK_INIT;
        foreach (bytes[j]) sum ^= bytes[j];
        if (flaw == BAD_CHECK)
            sum ^= 8'($urandom_range(1, 255));
        bytes.push_back(sum);
        cut = (flaw == CUT_SHORT) ? $urandom_range(1, 3) : 0;
        for (k = 0; k < bytes.size() - cut; k++)
            send_byte(bytes[k]);
    endtask

    // Stop offering and wait for every predicted frame to come out
    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] start_byte();
        return kfra_pkg::START_MATCH | (8'($urandom) & ~kfra_pkg::START_MASK);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ((b & kfra_pkg::START_MASK) == kfra_pkg::START_MATCH)
            b ^= 8'h40;
        return b;
    endfunction

    // Mostly short payloads, now and then any length
    function automatic logic [3:0] pick_nibble();
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom);
        return 4'($urandom_range(1, 5));
    endfunction

    initial begin : stimulus
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle noise, longest frame, short frame, bad check, mid-size frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h90, 4'hF, 1'b1, INTACT);
        send_frame(8'hBC, 4'h0, 1'b0, INTACT);
        send_frame(8'hB4, 4'h1, 1'b1, BAD_CHECK);
        send_frame(8'h98, 4'h7, 1'b0, INTACT);
        drain_results();

        // long result hold-off while frames keep coming, then a full pause
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (4) send_frame(start_byte(), 4'($urandom_range(1, 4)), 1'($urandom), INTACT);
        drain_results();

        // random traffic, idle mix changes as bytes accumulate
        while (bytes_sent < MIN_BYTES) begin
            if (bytes_sent < MIN_BYTES / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 48;
            end else if (bytes_sent < (2 * MIN_BYTES) / 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(start_byte(), pick_nibble(), 1'($urandom), INTACT);
            else if (pick < 80)
                send_frame(start_byte(), pick_nibble(), 1'($urandom), BAD_CHECK);
            else if (pick < 88)
                send_frame(start_byte(), pick_nibble(), 1'($urandom), CUT_SHORT);
            else
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_knx_frame_receive_assembler_unit: clean");
        else
            $display("tb_knx_frame_receive_assembler_unit: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("tb_knx_frame_receive_assembler_unit: errors");
        $finish;
    end

endmodule
